[rtl/core/dqks_pkg.sv]
package dqks_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_POP_EMPTY = 2'd1,
        STATUS_PUSH_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_BACK,
        CELL_SHIFT_FRONT,
        CELL_LOAD
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

    typedef struct packed {
        logic done;
        logic found;
    } scan_res_t;

    localparam int DATA_W  = 32;
    localparam int SCAN_W  = 8;
    localparam int POS_W   = 4;
    localparam int TOTAL_W = 5;

endpackage

[rtl/core/dqks_cell.sv]
module dqks_cell
    import dqks_pkg::*;
(
    input  logic                     clk,
    input  cell_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] prev_data,
    input  logic signed [DATA_W-1:0] next_data,
    input  logic signed [DATA_W-1:0] load_data,
    input  logic signed [DATA_W-1:0] key,
    output logic signed [DATA_W-1:0] data,
    output logic                     match
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        unique case (ctrl.op)
            CELL_HOLD:        data_next = data_reg;
            CELL_SHIFT_BACK:  data_next = prev_data;
            CELL_SHIFT_FRONT: data_next = next_data;
            CELL_LOAD:        data_next = load_data;
            default:          data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == key);

endmodule

[rtl/core/dqks_scan.sv]
module dqks_scan
    import dqks_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int NCHUNK = (DEPTH + SCAN_W - 1) / SCAN_W,
    localparam int VW     = NCHUNK * SCAN_W,
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1,
    localparam int EW     = $clog2(SCAN_W)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DEPTH-1:0] match,
    output scan_res_t        res,
    output logic [CW+EW-1:0] pos
);

    logic [VW-1:0] vec_reg;
    logic [CW-1:0] chunk_reg;
    logic          busy_reg;
    logic          hit;
    logic          last;
    logic [EW-1:0] enc;

    always_comb
    begin
        enc = '0;
        for (int k = SCAN_W - 1; k >= 0; k--)
        begin
            if (vec_reg[k])
            begin
                enc = EW'(k);
            end
        end
    end

    assign hit       = |vec_reg[SCAN_W-1:0];
    assign last      = (chunk_reg == CW'(NCHUNK - 1));
    assign res.done  = busy_reg && (hit || last);
    assign res.found = busy_reg && hit;
    assign pos       = {chunk_reg, enc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            chunk_reg <= '0;
            vec_reg   <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            chunk_reg <= '0;
            vec_reg   <= VW'(match);
        end
        else if (busy_reg)
        begin
            if (res.done)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                vec_reg   <= vec_reg >> SCAN_W;
                chunk_reg <= chunk_reg + CW'(1);
            end
        end
    end

endmodule

[rtl/core/deque_with_key_search.sv]
// push and pop items: result in the cycle after acceptance, one item per cycle
// while out_ready holds; search items: all cells compared on acceptance, then
// the match vector is scanned eight cells per cycle, the result is registered
// when the scan ends and the next item is taken once it is out
// reset clears the entry count and the handshake state; cell contents are not
// reset and are never read before a push writes them
module deque_with_key_search
    import dqks_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                opcode,
    input  logic signed [DATA_W-1:0]  value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      found,
    output logic [POS_W-1:0]          position,
    output logic [TOTAL_W-1:0]        entry_total,
    output logic                      is_empty,
    output logic [1:0]                status
);

    localparam int CNTW   = $clog2(DEPTH + 1);
    localparam int NCHUNK = (DEPTH + SCAN_W - 1) / SCAN_W;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int SPW    = CW + $clog2(SCAN_W);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    state_t                   state_reg;
    logic [CNTW-1:0]          count_reg;
    logic [CNTW-1:0]          count_next;
    logic                     out_valid_reg;
    logic                     found_reg;
    logic [POS_W-1:0]         position_reg;
    logic [TOTAL_W-1:0]       total_reg;
    logic                     empty_reg;
    status_t                  status_reg;
    status_t                  status_next;

    logic                     fire;
    logic                     is_full;
    logic                     is_none;
    opcode_t                  op;
    cell_op_t                 row_op;
    logic                     load_back;
    logic                     scan_start;
    scan_res_t                scan_res;
    logic [SPW-1:0]           scan_pos;

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]         cell_match;
    logic [DEPTH-1:0]         match_vec;

    assign op       = opcode_t'(opcode);
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign fire     = in_valid && in_ready;
    assign is_full  = (count_reg == CNTW'(DEPTH));
    assign is_none  = (count_reg == '0);
    assign scan_start = fire && (op == OP_SEARCH);

    always_comb
    begin
        count_next  = count_reg;
        status_next = STATUS_DONE;
        row_op      = CELL_HOLD;
        load_back   = 1'b0;
        unique case (op)
            OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status_next = STATUS_PUSH_FULL;
                end
                else
                begin
                    count_next = count_reg + CNTW'(1);
                    row_op     = CELL_SHIFT_BACK;
                end
            end
            OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = STATUS_PUSH_FULL;
                end
                else
                begin
                    count_next = count_reg + CNTW'(1);
                    load_back  = 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (is_none)
                begin
                    status_next = STATUS_POP_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNTW'(1);
                    row_op     = CELL_SHIFT_FRONT;
                end
            end
            OP_POP_BACK:
            begin
                if (is_none)
                begin
                    status_next = STATUS_POP_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNTW'(1);
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            cell_ctrl_t               ctrl;
            logic signed [DATA_W-1:0] prev_d;
            logic signed [DATA_W-1:0] next_d;

            always_comb
            begin
                ctrl.op = CELL_HOLD;
                if (fire)
                begin
                    if (load_back && (count_reg == CNTW'(gi)))
                    begin
                        ctrl.op = CELL_LOAD;
                    end
                    else
                    begin
                        ctrl.op = row_op;
                    end
                end
            end

            if (gi == 0)
            begin : g_head
                assign prev_d = value;
            end
            else
            begin : g_body
                assign prev_d = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign next_d = cell_data[gi];
            end
            else
            begin : g_inner
                assign next_d = cell_data[gi+1];
            end

            dqks_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .prev_data (prev_d),
                .next_data (next_d),
                .load_data (value),
                .key       (value),
                .data      (cell_data[gi]),
                .match     (cell_match[gi])
            );

            assign match_vec[gi] = cell_match[gi] && (CNTW'(gi) < count_reg);
        end
    endgenerate

    dqks_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .match (match_vec),
        .res   (scan_res),
        .pos   (scan_pos)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            position_reg  <= '0;
            total_reg     <= '0;
            empty_reg     <= 1'b1;
            status_reg    <= STATUS_DONE;
        end
        else
        begin
            if ((state_reg == S_IDLE && fire && op != OP_SEARCH)
                || (state_reg == S_SEARCH && scan_res.done))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (fire)
                    begin
                        count_reg <= count_next;
                        if (op == OP_SEARCH)
                        begin
                            state_reg <= S_SEARCH;
                        end
                        else
                        begin
                            found_reg     <= 1'b0;
                            position_reg  <= '0;
                            total_reg     <= TOTAL_W'(count_next);
                            empty_reg     <= (count_next == '0);
                            status_reg    <= status_next;
                        end
                    end
                end
                S_SEARCH:
                begin
                    if (scan_res.done)
                    begin
                        state_reg     <= S_IDLE;
                        found_reg     <= scan_res.found;
                        position_reg  <= scan_res.found ? POS_W'(scan_pos) : '0;
                        total_reg     <= TOTAL_W'(count_reg);
                        empty_reg     <= is_none;
                        status_reg    <= STATUS_DONE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign entry_total = total_reg;
    assign is_empty    = empty_reg;
    assign status      = status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(DEPTH))
        else $error("entry count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && !is_full
        |=> count_reg == $past(count_reg) + CNTW'(1))
        else $error("push did not grow the count");

    a_scan_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        scan_res.done |-> state_reg == S_SEARCH)
        else $error("scan finished outside a search");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> empty_reg == (total_reg == '0 && count_reg == '0)
                          || (DEPTH >= 32))
        else $error("empty flag disagrees with count");

    a_search_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |=> $stable(count_reg))
        else $error("count changed during a search");
`endif

endmodule
